// ===== sv/pixel_component_format_converter_defines.svh =====
// Assertion macros for the pixel component format converter.
// No dependencies.
`ifndef PIXEL_COMPONENT_FORMAT_CONVERTER_DEFINES_SVH
`define PIXEL_COMPONENT_FORMAT_CONVERTER_DEFINES_SVH
`ifndef SYNTHESIS
`define PCFC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PCFC_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`else
`define PCFC_ASSERT(label, clk, rst_n, prop, msg)
`define PCFC_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)
`endif
`endif

// ===== sv/pcfc_pkg.sv =====
// Package for the pixel component format converter: modes and the lane result type.
// No dependencies.
package pcfc_pkg;

    localparam int unsigned COMP_W = 32;
    localparam int unsigned LANES  = 4;

    typedef enum logic [2:0] {
        MODE_AYUV16_YUV8   = 3'd0,
        MODE_AYUV16_YUVA8  = 3'd1,
        MODE_YUV8_AYUV16   = 3'd2,
        MODE_YUVA8_AYUV16  = 3'd3,
        MODE_RGBA16_RGBF   = 3'd4,
        MODE_RGBA16_RGBAF  = 3'd5,
        MODE_RGBF_RGBA16   = 3'd6,
        MODE_RGBAF_RGBA16  = 3'd7
    } mode_t;

    typedef struct packed {
        logic [7:0]  shr8;
        logic [15:0] shl8;
        logic [31:0] to_float;
        logic [15:0] to_u16;
    } lane_res_t;

endpackage

// ===== sv/pcfc_lane.sv =====
// One conversion lane: all four component conversions of one value.
// Depends on pcfc_pkg.
module pcfc_lane
(
    input  logic [31:0]            comp,
    output pcfc_pkg::lane_res_t    res
);

    logic [15:0] v;
    logic [4:0]  lz;
    logic [15:0] norm;
    logic [47:0] q;
    logic [23:0] mant;
    logic [7:0]  fexp;
    logic [7:0]  e;
    logic [22:0] m;
    logic [23:0] sig;
    logic [47:0] p;
    logic [47:0] ip;
    logic        found;
    logic [31:0] f_bits;
    logic [15:0] u_bits;

    // v/65535 = v*(1+2^-16+2^-32+...)/65536; round the bit string to 24 bits.
    always_comb
    begin
        v = comp[15:0];
        lz = 5'd0;
        found = 1'b0;
        fexp = 8'd0;
        for (int i = 15; i >= 0; i--)
        begin
            if (!found && v[i])
            begin
                found = 1'b1;
                lz = 5'(15 - i);
            end
        end
        norm = v << lz;
        q = {norm, norm, norm};
        mant = q[47:24] + 24'(q[23]);
        if (v == 16'hffff)
            f_bits = 32'h3f80_0000;
        else if (v == 16'd0)
            f_bits = 32'd0;
        else
        begin
            fexp = 8'(8'd126 - 8'(lz));
            f_bits = {1'b0, fexp, mant[22:0]};
        end
    end

    // f*65535 truncated, saturated.
    always_comb
    begin
        e   = comp[30:23];
        m   = comp[22:0];
        sig = {1'b1, m};
        p   = ({sig, 16'd0}) - {24'd0, sig};
        ip  = 48'd0;
        if (e >= 8'd127 || e < 8'd103)
            ip = 48'd0;
        else
            ip = p >> (8'd150 - e);
        if (comp[31] || (e == 8'hff && m != 23'd0))
            u_bits = 16'd0;
        else if (e >= 8'd127)
            u_bits = 16'hffff;
        else
            u_bits = ip[15:0];
    end

    assign res = {comp[15:8], comp[7:0], 8'd0, f_bits, u_bits};

endmodule

// ===== sv/pcfc_merge.sv =====
// Merge stage: picks lane results per mode into the output components.
// Depends on pcfc_pkg.
module pcfc_merge
(
    input  pcfc_pkg::mode_t        mode,
    input  pcfc_pkg::lane_res_t    r0,
    input  pcfc_pkg::lane_res_t    r1,
    input  pcfc_pkg::lane_res_t    r2,
    input  pcfc_pkg::lane_res_t    r3,
    output logic [31:0]            o0,
    output logic [31:0]            o1,
    output logic [31:0]            o2,
    output logic [31:0]            o3,
    output logic [2:0]             cnt
);

    always_comb
    begin
        o0 = 32'd0;
        o1 = 32'd0;
        o2 = 32'd0;
        o3 = 32'd0;
        cnt = 3'd4;
        case (mode)
            pcfc_pkg::MODE_AYUV16_YUV8, pcfc_pkg::MODE_AYUV16_YUVA8:
            begin
                o0 = {24'd0, r1.shr8};
                o1 = {24'd0, r2.shr8};
                o2 = {24'd0, r3.shr8};
                if (mode == pcfc_pkg::MODE_AYUV16_YUVA8)
                    o3 = {24'd0, r0.shr8};
                else
                    cnt = 3'd3;
            end
            pcfc_pkg::MODE_YUV8_AYUV16, pcfc_pkg::MODE_YUVA8_AYUV16:
            begin
                o0 = (mode == pcfc_pkg::MODE_YUVA8_AYUV16) ? {16'd0, r3.shl8} : 32'h0000_ffff;
                o1 = {16'd0, r0.shl8};
                o2 = {16'd0, r1.shl8};
                o3 = {16'd0, r2.shl8};
            end
            pcfc_pkg::MODE_RGBA16_RGBF, pcfc_pkg::MODE_RGBA16_RGBAF:
            begin
                o0 = r0.to_float;
                o1 = r1.to_float;
                o2 = r2.to_float;
                if (mode == pcfc_pkg::MODE_RGBA16_RGBAF)
                    o3 = r3.to_float;
                else
                    cnt = 3'd3;
            end
            default:
            begin
                o0 = {16'd0, r0.to_u16};
                o1 = {16'd0, r1.to_u16};
                o2 = {16'd0, r2.to_u16};
                o3 = (mode == pcfc_pkg::MODE_RGBAF_RGBA16) ? {16'd0, r3.to_u16}
                                                           : 32'h0000_ffff;
            end
        endcase
    end

endmodule

// ===== sv/pixel_component_format_converter.sv =====
// Top level of the pixel component format converter: four lanes, merge, output register.
// Depends on pcfc_pkg, pcfc_lane, pcfc_merge and the defines header.
//
//  channel | signals                                    | direction
//  input   | in_valid/in_ready, in_comp0..3             | in
//  output  | out_valid/out_ready, out_comp0..3, out_count | out
//  config  | cfg_we, cfg_data                           | in
//
// One pixel per cycle while out_ready holds; out_valid rises the cycle after in_xfer.
// The single output register sets the latency; in_ready follows out_ready
// when the register is full. Reset empties it and sets mode 0.
`include "pixel_component_format_converter_defines.svh"
module pixel_component_format_converter
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] in_comp0,
    input  logic [31:0] in_comp1,
    input  logic [31:0] in_comp2,
    input  logic [31:0] in_comp3,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_comp0,
    output logic [31:0] out_comp1,
    output logic [31:0] out_comp2,
    output logic [31:0] out_comp3,
    output logic [2:0]  out_count
);

    pcfc_pkg::mode_t     mode_reg;
    logic                valid_reg;
    logic [31:0]         c0_reg, c1_reg, c2_reg, c3_reg;
    logic [2:0]          cnt_reg;
    pcfc_pkg::lane_res_t r0, r1, r2, r3;
    logic [31:0]         c0_next, c1_next, c2_next, c3_next;
    logic [2:0]          cnt_next;
    logic                in_xfer;

    pcfc_lane u_lane0 (.comp(in_comp0), .res(r0));
    pcfc_lane u_lane1 (.comp(in_comp1), .res(r1));
    pcfc_lane u_lane2 (.comp(in_comp2), .res(r2));
    pcfc_lane u_lane3 (.comp(in_comp3), .res(r3));

    pcfc_merge u_merge
    (
        .mode(mode_reg), .r0(r0), .r1(r1), .r2(r2), .r3(r3),
        .o0(c0_next), .o1(c1_next), .o2(c2_next), .o3(c3_next), .cnt(cnt_next)
    );

    assign in_ready  = !valid_reg || out_ready;
    assign in_xfer   = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_comp0 = c0_reg;
    assign out_comp1 = c1_reg;
    assign out_comp2 = c2_reg;
    assign out_comp3 = c3_reg;
    assign out_count = cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= pcfc_pkg::MODE_AYUV16_YUV8;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                mode_reg <= pcfc_pkg::mode_t'(cfg_data);
            if (in_xfer)
                valid_reg <= 1'b1;
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            c0_reg  <= c0_next;
            c1_reg  <= c1_next;
            c2_reg  <= c2_next;
            c3_reg  <= c3_next;
            cnt_reg <= cnt_next;
        end
    end

    `PCFC_ASSERT(a_count_range, clk, rst_n, !valid_reg || cnt_reg == 3'd3 || cnt_reg == 3'd4, "bad count")
    `PCFC_ASSERT_NEXT(a_hold, clk, rst_n, valid_reg && !out_ready, valid_reg && $stable(c0_reg), "result lost")
    `PCFC_ASSERT_NEXT(a_fill, clk, rst_n, in_xfer, valid_reg, "transfer dropped")

endmodule
